// ===== hdl/rvex_pkg.sv =====
// Shared types and constants of the RV32I execute unit.
package rvex_pkg;

  // Major opcodes.
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcImm    = 7'h13;
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcSystem = 7'h73;
  localparam logic [6:0] OpcFence  = 7'h0F;

  // ALU funct3 codes.
  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Sr   = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  // Branch funct3 codes.
  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  // Load and store width codes.
  localparam logic [2:0] F3Byte  = 3'd0;
  localparam logic [2:0] F3Half  = 3'd1;
  localparam logic [2:0] F3Word  = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4;
  localparam logic [2:0] F3HalfU = 3'd5;
  localparam logic [2:0] F3Res3  = 3'd3;
  localparam logic [2:0] F3Res6  = 3'd6;
  localparam logic [2:0] F3Res7  = 3'd7;

  localparam logic [6:0] F7Zero = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;

  localparam logic [31:0] PcStep    = 32'd4;
  localparam int unsigned ShamtW    = 5;
  localparam int unsigned UpperBits = 12;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNSUPPORTED,
    ST_ILLEGAL
  } status_e;

  typedef enum logic [3:0] {
    K_PRELOAD,
    K_LUI,
    K_AUIPC,
    K_JAL,
    K_JALR,
    K_BRANCH,
    K_LOAD,
    K_STORE,
    K_ALU,
    K_NOP
  } kind_e;

  // Decoded operation as it travels from the front to the back.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic        alt;
    logic        use_imm;
    logic [31:0] imm;
    logic [11:0] pl_addr;
    logic [7:0]  pl_data;
  } uop_t;

  typedef struct packed {
    logic push;
    uop_t uop;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
    uop_t head;
  } q_rd_t;

endpackage

// ===== hdl/rvex_if.sv =====
// Handshake interfaces of the execute unit's input and result channels.
interface rvex_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] instr_word;
  logic [11:0] preload_addr;
  logic [7:0]  preload_data;

  modport source (output valid, cmd, instr_word, preload_addr, preload_data, input ready);
  modport sink (input valid, cmd, instr_word, preload_addr, preload_data, output ready);
endinterface

interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        rd_written;
  logic [4:0]  rd_index;
  logic [31:0] rd_value;
  logic        mem_written;
  logic [11:0] mem_addr;
  logic [2:0]  mem_bytes;
  logic [31:0] mem_data;
  logic [1:0]  status;

  modport source (output valid, next_pc, rd_written, rd_index, rd_value, mem_written,
                  mem_addr, mem_bytes, mem_data, status, input ready);
  modport sink (input valid, next_pc, rd_written, rd_index, rd_value, mem_written,
                mem_addr, mem_bytes, mem_data, status, output ready);
endinterface

// ===== hdl/rvex_front.sv =====
// Front end: accepts input transactions and decodes them into operations.
module rvex_front (
  rvex_in_if.sink            in_i,
  input  logic               q_full_i,
  input  logic               busy_i,
  output rvex_pkg::q_wr_t    q_o
);

  logic [31:0]     w;
  logic [31:0]     imm_i;
  rvex_pkg::uop_t  uop;

  // Accept whenever the queue has room and memory clearing is over.
  assign in_i.ready = !q_full_i && !busy_i;
  assign w          = in_i.instr_word;
  assign imm_i      = {{20{w[31]}}, w[31:20]};

  // Instruction decoder with legality checks.
  always_comb begin
    uop         = '0;
    uop.kind    = rvex_pkg::K_NOP;
    uop.status  = rvex_pkg::ST_OK;
    uop.rd      = w[11:7];
    uop.rs1     = w[19:15];
    uop.rs2     = w[24:20];
    uop.f3      = w[14:12];
    uop.imm     = imm_i;
    uop.pl_addr = in_i.preload_addr;
    uop.pl_data = in_i.preload_data;
    if (in_i.cmd) begin
      uop.kind = rvex_pkg::K_PRELOAD;
    end else begin
      unique case (w[6:0])
        rvex_pkg::OpcLui: begin
          uop.kind = rvex_pkg::K_LUI;
          uop.imm  = {w[31:rvex_pkg::UpperBits], {rvex_pkg::UpperBits{1'b0}}};
        end
        rvex_pkg::OpcAuipc: begin
          uop.kind = rvex_pkg::K_AUIPC;
          uop.imm  = {w[31:rvex_pkg::UpperBits], {rvex_pkg::UpperBits{1'b0}}};
        end
        rvex_pkg::OpcJal: begin
          uop.kind = rvex_pkg::K_JAL;
          uop.imm  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        rvex_pkg::OpcJalr: begin
          if (w[14:12] != 3'd0) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_JALR;
          end
        end
        rvex_pkg::OpcBranch: begin
          if (w[14:12] == rvex_pkg::F3Slt || w[14:12] == rvex_pkg::F3Sltu) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_BRANCH;
            uop.imm  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
          end
        end
        rvex_pkg::OpcLoad: begin
          if (w[14:12] inside {rvex_pkg::F3Res3, rvex_pkg::F3Res6, rvex_pkg::F3Res7}) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_LOAD;
          end
        end
        rvex_pkg::OpcStore: begin
          if (w[14:12] > rvex_pkg::F3Word) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_STORE;
            uop.imm  = {{21{w[31]}}, w[30:25], w[11:7]};
          end
        end
        rvex_pkg::OpcImm: begin
          uop.use_imm = 1'b1;
          if (w[14:12] == rvex_pkg::F3Sll && w[31:25] != rvex_pkg::F7Zero) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else if (w[14:12] == rvex_pkg::F3Sr && w[31:25] != rvex_pkg::F7Zero
                       && w[31:25] != rvex_pkg::F7Alt) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_ALU;
            uop.alt  = (w[14:12] == rvex_pkg::F3Sr) && (w[31:25] == rvex_pkg::F7Alt);
          end
        end
        rvex_pkg::OpcOp: begin
          if (w[31:25] != rvex_pkg::F7Zero && !(w[31:25] == rvex_pkg::F7Alt
              && (w[14:12] == rvex_pkg::F3Add || w[14:12] == rvex_pkg::F3Sr))) begin
            uop.status = rvex_pkg::ST_ILLEGAL;
          end else begin
            uop.kind = rvex_pkg::K_ALU;
            uop.alt  = (w[31:25] == rvex_pkg::F7Alt);
          end
        end
        rvex_pkg::OpcSystem, rvex_pkg::OpcFence: begin
          uop.status = rvex_pkg::ST_UNSUPPORTED;
        end
        default: begin
          uop.status = rvex_pkg::ST_ILLEGAL;
        end
      endcase
    end
  end

  assign q_o.push = in_i.valid && in_i.ready;
  assign q_o.uop  = uop;

endmodule

// ===== hdl/rvex_fifo.sv =====
// Two-entry queue of decoded operations between front and back.
module rvex_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvex_pkg::q_wr_t wr_i,
  input  logic            pop_i,
  output rvex_pkg::q_rd_t rd_o
);

  rvex_pkg::uop_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;

  assign rd_o.empty = (cnt_q == 2'd0);
  assign rd_o.full  = (cnt_q == 2'd2);
  assign rd_o.head  = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      entry_q[wr_ptr_q] <= wr_i.uop;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_i.push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !wr_i.push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/rvex_back.sv =====
// Back end: register file, data memory, execution and the result register.
module rvex_back #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvex_pkg::q_rd_t q_i,
  output logic            pop_o,
  output logic            busy_o,
  rvex_out_if.source      out_o
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned Rows = MEM_BYTES / 4;
  localparam int unsigned RW   = AW - 2;
  localparam logic [31:0] SpReset = 32'(MEM_BYTES);
  localparam logic [4:0]  SpIdx   = 5'd2;
  localparam int unsigned ShamtWL = rvex_pkg::ShamtW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e         state_q;
  rvex_pkg::uop_t cur_q;
  logic [31:0]    pc_q;
  logic [RW-1:0]  clr_q;
  logic [31:0]    rf_vld_q;
  logic [31:0]    rf_mem [32];
  logic [31:0]    rs1_q, rs2_q;
  logic           rs1_vld_q, rs2_vld_q;

  logic           out_valid_q;
  logic [31:0]    o_next_pc_q, o_rd_value_q, o_mem_data_q;
  logic           o_rd_written_q, o_mem_written_q;
  logic [4:0]     o_rd_index_q;
  logic [11:0]    o_mem_addr_q;
  logic [2:0]     o_mem_bytes_q;
  logic [1:0]     o_status_q;

  logic [31:0]    a, b, op2, alu, ea, pc4, npc, res, sdata, ld_raw, ld_val, addr32, pl32;
  logic [AW-1:0]  ea_w, pl_w;
  logic [ShamtWL-1:0] sh;
  logic           take, wr, out_free, finish, rf_we;
  logic [2:0]     nbytes, sb;
  logic [7:0]     ld_b [4];
  logic [1:0]     lane [4];
  logic [AW-1:0]  baddr [4];
  logic           bank_we [4];
  logic           bank_re;
  logic [RW-1:0]  bank_wa [4];
  logic [RW-1:0]  bank_ra [4];
  logic [7:0]     bank_wd [4];
  logic [7:0]     bank_rd_q [4];
  logic [31:0]    r_rd_value, r_mem_data;
  logic           r_rd_written, r_mem_written;
  logic [11:0]    r_mem_addr;

  function automatic logic [31:0] rf_reset(input logic [4:0] idx);
    return (idx == SpIdx) ? SpReset : 32'd0;
  endfunction

  // Operand values: entries never written read as their reset value.
  assign a   = rs1_vld_q ? rs1_q : rf_reset(cur_q.rs1);
  assign b   = rs2_vld_q ? rs2_q : rf_reset(cur_q.rs2);
  assign op2 = cur_q.use_imm ? cur_q.imm : b;
  assign sh  = op2[ShamtWL-1:0];
  assign ea  = a + cur_q.imm;
  assign ea_w = ea[AW-1:0];
  assign pc4 = pc_q + rvex_pkg::PcStep;
  assign pl32 = 32'(cur_q.pl_addr);
  assign pl_w = pl32[AW-1:0];
  assign addr32 = 32'(ea_w);

  // Integer ALU.
  always_comb begin
    case (cur_q.f3)
      rvex_pkg::F3Add:  alu = cur_q.alt ? a - op2 : a + op2;
      rvex_pkg::F3Sll:  alu = a << sh;
      rvex_pkg::F3Slt:  alu = {31'd0, $signed(a) < $signed(op2)};
      rvex_pkg::F3Sltu: alu = {31'd0, a < op2};
      rvex_pkg::F3Xor:  alu = a ^ op2;
      rvex_pkg::F3Sr:   alu = cur_q.alt ? 32'($signed(a) >>> sh) : a >> sh;
      rvex_pkg::F3Or:   alu = a | op2;
      default:          alu = a & op2;
    endcase
  end

  // Branch condition.
  always_comb begin
    case (cur_q.f3)
      rvex_pkg::F3Beq:  take = (a == b);
      rvex_pkg::F3Bne:  take = (a != b);
      rvex_pkg::F3Blt:  take = ($signed(a) < $signed(b));
      rvex_pkg::F3Bge:  take = ($signed(a) >= $signed(b));
      rvex_pkg::F3Bltu: take = (a < b);
      rvex_pkg::F3Bgeu: take = (a >= b);
      default:          take = 1'b0;
    endcase
  end

  // Store size and data, masked to the stored bytes.
  always_comb begin
    case (cur_q.f3)
      rvex_pkg::F3Byte: begin
        nbytes = 3'd1;
        sdata  = {24'd0, b[7:0]};
      end
      rvex_pkg::F3Half: begin
        nbytes = 3'd2;
        sdata  = {16'd0, b[15:0]};
      end
      default: begin
        nbytes = 3'd4;
        sdata  = b;
      end
    endcase
  end

  // Load data: byte i of the access sits in bank (address + i) mod 4.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_b[i] = bank_rd_q[ea_w[1:0] + 2'(i)];
    end
    ld_raw = {ld_b[3], ld_b[2], ld_b[1], ld_b[0]};
    case (cur_q.f3)
      rvex_pkg::F3Byte:  ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      rvex_pkg::F3Half:  ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      rvex_pkg::F3ByteU: ld_val = {24'd0, ld_raw[7:0]};
      rvex_pkg::F3HalfU: ld_val = {16'd0, ld_raw[15:0]};
      default:           ld_val = ld_raw;
    endcase
  end

  // Result of the current operation.
  always_comb begin
    npc = pc4;
    res = 32'd0;
    wr  = 1'b0;
    sb  = 3'd0;
    case (cur_q.kind)
      rvex_pkg::K_LUI: begin
        res = cur_q.imm;
        wr  = 1'b1;
      end
      rvex_pkg::K_AUIPC: begin
        res = pc_q + cur_q.imm;
        wr  = 1'b1;
      end
      rvex_pkg::K_JAL: begin
        res = pc4;
        wr  = 1'b1;
        npc = pc_q + cur_q.imm;
      end
      rvex_pkg::K_JALR: begin
        res = pc4;
        wr  = 1'b1;
        npc = {ea[31:1], 1'b0};
      end
      rvex_pkg::K_BRANCH: begin
        if (take) begin
          npc = pc_q + cur_q.imm;
        end
      end
      rvex_pkg::K_LOAD: begin
        res = ld_val;
        wr  = 1'b1;
      end
      rvex_pkg::K_STORE: begin
        sb = nbytes;
      end
      rvex_pkg::K_ALU: begin
        res = alu;
        wr  = 1'b1;
      end
      default: begin
        npc = pc_q;
      end
    endcase
    r_rd_written  = wr && (cur_q.rd != 5'd0);
    r_rd_value    = r_rd_written ? res : 32'd0;
    r_mem_written = (sb != 3'd0);
    r_mem_addr    = r_mem_written ? addr32[11:0] : 12'd0;
    r_mem_data    = r_mem_written ? sdata : 32'd0;
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign finish   = ((state_q == S_EXEC) && (cur_q.kind != rvex_pkg::K_LOAD) && out_free)
                    || ((state_q == S_LOAD) && out_free);
  assign rf_we    = finish && r_rd_written;
  assign pop_o    = (state_q == S_IDLE) && !q_i.empty;
  assign busy_o   = (state_q == S_CLEAR);
  assign bank_re  = (state_q == S_EXEC) && (cur_q.kind == rvex_pkg::K_LOAD);

  // Bank addressing and write selection: clearing pass, preload or store.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      lane[g]    = 2'(g) - ea_w[1:0];
      baddr[g]   = ea_w + AW'(lane[g]);
      bank_ra[g] = baddr[g][AW-1:2];
      bank_wa[g] = baddr[g][AW-1:2];
      bank_wd[g] = 8'(sdata >> {lane[g], 3'b000});
      bank_we[g] = 1'b0;
      if (state_q == S_CLEAR) begin
        bank_we[g] = 1'b1;
        bank_wa[g] = clr_q;
        bank_wd[g] = 8'd0;
      end else if (finish && cur_q.kind == rvex_pkg::K_PRELOAD) begin
        bank_we[g] = (pl_w[1:0] == 2'(g));
        bank_wa[g] = pl_w[AW-1:2];
        bank_wd[g] = cur_q.pl_data;
      end else if (finish && cur_q.kind == rvex_pkg::K_STORE) begin
        bank_we[g] = (3'(lane[g]) < nbytes);
      end
    end
  end

  // Data memory: four byte-wide banks.
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [Rows];
    always_ff @(posedge clk_i) begin
      if (bank_we[g]) begin
        mem[bank_wa[g]] <= bank_wd[g];
      end
      if (bank_re) begin
        bank_rd_q[g] <= mem[bank_ra[g]];
      end
    end
  end

  // Register file with registered reads.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[cur_q.rd] <= res;
    end
    if (pop_o) begin
      rs1_q <= rf_mem[q_i.head.rs1];
      rs2_q <= rf_mem[q_i.head.rs2];
    end
  end

  // Sequencer, program counter and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= 32'd0;
      rf_vld_q    <= 32'd0;
      rs1_vld_q   <= 1'b0;
      rs2_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q     <= 1'b1;
        o_next_pc_q     <= npc;
        o_rd_written_q  <= r_rd_written;
        o_rd_index_q    <= r_rd_written ? cur_q.rd : 5'd0;
        o_rd_value_q    <= r_rd_value;
        o_mem_written_q <= r_mem_written;
        o_mem_addr_q    <= r_mem_addr;
        o_mem_bytes_q   <= sb;
        o_mem_data_q    <= r_mem_data;
        o_status_q      <= cur_q.status;
        pc_q            <= npc;
        if (r_rd_written) begin
          rf_vld_q[cur_q.rd] <= 1'b1;
        end
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == RW'(Rows - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_i.empty) begin
            cur_q     <= q_i.head;
            rs1_vld_q <= rf_vld_q[q_i.head.rs1];
            rs2_vld_q <= rf_vld_q[q_i.head.rs2];
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur_q.kind == rvex_pkg::K_LOAD) begin
            state_q <= S_LOAD;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.next_pc     = o_next_pc_q;
  assign out_o.rd_written  = o_rd_written_q;
  assign out_o.rd_index    = o_rd_index_q;
  assign out_o.rd_value    = o_rd_value_q;
  assign out_o.mem_written = o_mem_written_q;
  assign out_o.mem_addr    = o_mem_addr_q;
  assign out_o.mem_bytes   = o_mem_bytes_q;
  assign out_o.mem_data    = o_mem_data_q;
  assign out_o.status      = o_status_q;

endmodule

// ===== hdl/rv32i_execute_unit.sv =====
// Top level of the RV32I execute unit: front decoder, queue and back end.
// Input transactions are taken in any cycle while the two-entry queue has room and no clearing pass runs.
// Each instruction passes a register-file read state and then execute; loads add a data
// memory read state. The back end finishes one instruction before it takes the next, and
// a result register that is not yet free holds it in execute (or in the load state).
// After reset a clearing pass zeroes all MEM_BYTES/4 memory rows; input stays not ready.
module rv32i_execute_unit #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvex_in_if.sink    in_i,
  rvex_out_if.source out_o
);

  rvex_pkg::q_wr_t q_wr;
  rvex_pkg::q_rd_t q_rd;
  logic            pop;
  logic            busy;

  rvex_front u_front (
    .in_i     (in_i),
    .q_full_i (q_rd.full),
    .busy_i   (busy),
    .q_o      (q_wr)
  );

  rvex_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (pop),
    .rd_o   (q_rd)
  );

  rvex_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_rd),
    .pop_o  (pop),
    .busy_o (busy),
    .out_o  (out_o)
  );

endmodule

// ===== hdl/rvex_checker.sv =====
// Port-level checks of the execute unit, bound to the top level.
module rvex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] next_pc_i,
  input logic        rd_written_i,
  input logic [4:0]  rd_index_i,
  input logic        mem_written_i,
  input logic [2:0]  mem_bytes_i,
  input logic [1:0]  status_i
);

  // A result transaction that waits stays valid and keeps its next PC and status.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_pc_i) && $stable(status_i))
    else $error("result changed while stalled");

  // A faulting instruction changes no register and no memory.
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != 2'd0) |-> !rd_written_i && !mem_written_i)
    else $error("faulting instruction reported a write");

  // Store size agrees with the store flag.
  a_store_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mem_written_i && (mem_bytes_i == 3'd1 || mem_bytes_i == 3'd2
                     || mem_bytes_i == 3'd4)) || (!mem_written_i && mem_bytes_i == 3'd0))
    else $error("store size inconsistent");

  // x0 is never reported as written.
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rd_written_i |-> rd_index_i != 5'd0)
    else $error("write to x0 reported");

endmodule

bind rv32i_execute_unit rvex_checker u_rvex_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .next_pc_i     (out_o.next_pc),
  .rd_written_i  (out_o.rd_written),
  .rd_index_i    (out_o.rd_index),
  .mem_written_i (out_o.mem_written),
  .mem_bytes_i   (out_o.mem_bytes),
  .status_i      (out_o.status)
);
